// ===== design/iirdf2_pkg.sv =====
// Shared types, constants and register decoding for the direct form II IIR filter.
`default_nettype none

package iirdf2_pkg;

	// Fixed number formats of the datapath.
	localparam int W_BITS        = 40;
	localparam int W_FRAC        = 30;
	localparam int OUT_BITS      = 32;
	localparam int OUT_FRAC      = 24;
	localparam int W_SPLIT       = 20;
	localparam int HALF_BITS     = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int SLOT_BITS     = 3;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_B0_B1 = 3'd0;
	localparam cfg_idx_t CFG_B2_B3 = 3'd1;
	localparam cfg_idx_t CFG_B4_B5 = 3'd2;
	localparam cfg_idx_t CFG_B6_A1 = 3'd3;
	localparam cfg_idx_t CFG_A2_A3 = 3'd4;
	localparam cfg_idx_t CFG_A4_A5 = 3'd5;
	localparam cfg_idx_t CFG_A6    = 3'd6;

	// Target of one 32-bit half of a configuration word.
	typedef struct packed {
		logic                 en;
		logic                 is_a;
		logic [SLOT_BITS-1:0] idx;
	} coef_slot_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic issue;
		logic hi;
		logic sub;
		logic init;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB,
		ST_FB_DRAIN,
		ST_WSAT,
		ST_FF,
		ST_FF_DRAIN,
		ST_DONE
	} seq_state_t;

	// Coefficient held in the upper half of a register.
	function automatic coef_slot_t slot_hi(cfg_idx_t r);
		coef_slot_t s;
		s = '0;
		case (r)
			CFG_B0_B1: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd0};
			CFG_B2_B3: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd2};
			CFG_B4_B5: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd4};
			CFG_B6_A1: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd6};
			CFG_A2_A3: s = '{en: 1'b1, is_a: 1'b1, idx: 3'd2};
			CFG_A4_A5: s = '{en: 1'b1, is_a: 1'b1, idx: 3'd4};
			default:   s = '0;
		endcase
		return s;
	endfunction

	// Coefficient held in the lower half of a register.
	function automatic coef_slot_t slot_lo(cfg_idx_t r);
		coef_slot_t s;
		s = '0;
		case (r)
			CFG_B0_B1: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd1};
			CFG_B2_B3: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd3};
			CFG_B4_B5: s = '{en: 1'b1, is_a: 1'b0, idx: 3'd5};
			CFG_B6_A1: s = '{en: 1'b1, is_a: 1'b1, idx: 3'd1};
			CFG_A2_A3: s = '{en: 1'b1, is_a: 1'b1, idx: 3'd3};
			CFG_A4_A5: s = '{en: 1'b1, is_a: 1'b1, idx: 3'd5};
			CFG_A6:    s = '{en: 1'b1, is_a: 1'b1, idx: 3'd6};
			default:   s = '0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== design/iirdf2_if.sv =====
// Handshake channel interfaces for samples, results and configuration writes.
`default_nettype none

interface iirdf2_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf2_out_if;
	import iirdf2_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] filtered_out;
	logic                       saturated;

	modport source (output valid, output filtered_out, output saturated, input ready);
	modport sink (input valid, input filtered_out, input saturated, output ready);
endinterface

interface iirdf2_cfg_if;
	import iirdf2_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/iirdf2_mac.sv =====
// Shared multiply-accumulate unit: coefficient times 40-bit state in two halves.
`default_nettype none

module iirdf2_mac #(
	parameter int COEF_BITS = 32,
	parameter int ACC_BITS  = 50
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  iirdf2_pkg::mac_ctl_t               ctl,
	input  wire signed [COEF_BITS-1:0]         coef,
	input  wire signed [iirdf2_pkg::W_BITS-1:0] wval,
	input  wire signed [ACC_BITS-1:0]          init_val,
	output logic signed [ACC_BITS-1:0]         acc,
	output logic                               busy
);
	import iirdf2_pkg::*;

	localparam int OPW       = W_SPLIT + 1;
	localparam int MPW       = COEF_BITS + OPW;
	localparam int PW        = COEF_BITS + W_BITS;
	localparam int COEF_FRAC = COEF_BITS - 4;
	localparam int TW        = PW - COEF_FRAC;

	logic signed [OPW-1:0] opw;
	logic signed [MPW-1:0] prod;
	logic signed [MPW-1:0] prod_s1;
	logic signed [MPW-1:0] plo_q;
	logic                  v_s1;
	logic                  hi_s1;
	logic                  sub_s1;
	logic signed [PW-1:0]  full;
	logic signed [TW-1:0]  term_s2;
	logic                  v_s2;
	logic                  sub_s2;
	logic signed [ACC_BITS-1:0] term_ext;

	// Upper half is signed, lower half is taken as a positive number.
	assign opw = ctl.hi ? $signed({wval[W_BITS-1], wval[W_BITS-1:W_SPLIT]})
	                    : $signed({1'b0, wval[W_SPLIT-1:0]});

	assign prod = $signed({{(MPW-COEF_BITS){coef[COEF_BITS-1]}}, coef})
	            * $signed({{(MPW-OPW){opw[OPW-1]}}, opw});

	// Stage 1: multiplier output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		hi_s1   <= ctl.hi;
		sub_s1  <= ctl.sub;
		if (v_s1 && !hi_s1) begin
			plo_q <= prod_s1;
		end
	end

	// Stage 2: join both halves and round the product towards minus infinity.
	assign full = ($signed({{(PW-MPW){prod_s1[MPW-1]}}, prod_s1}) <<< W_SPLIT)
	            + $signed({{(PW-MPW){plo_q[MPW-1]}}, plo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && hi_s1;
		end
	end

	always_ff @(posedge clk) begin
		term_s2 <= full[PW-1:COEF_FRAC];
		sub_s2  <= sub_s1;
	end

	// Stage 3: accumulate the rounded product.
	assign term_ext = $signed({{(ACC_BITS-TW){term_s2[TW-1]}}, term_s2});

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc <= init_val;
		end else if (v_s2) begin
			acc <= sub_s2 ? acc - term_ext : acc + term_ext;
		end
	end

	assign busy = v_s1 | v_s2;

endmodule

`default_nettype wire

// ===== design/iir_direct_form2_filter_unit.sv =====
// Top level of the direct form II IIR filter with a shared multiply-accumulate unit.
//
//  channel     direction  payload                      transfer
//  sample_ch   in         sample_in                    valid & ready
//  result_ch   out        filtered_out, saturated      valid & ready
//  cfg_ch      in         index, data                  valid & ready (always ready)
//
// The result is offered once the feedback and feedforward sums are done, and the next sample
// can be taken as soon as it is offered, so the filter works on one sample at a time.
// The single 32x21 multiplier needs two passes per coefficient, and its three-stage
// pipeline drains once after the feedback sum and once after the feedforward sum.
// Reset clears the coefficients, the delay line and all control state.
// A waiting result holds in the output register; a new sample is taken meanwhile,
// and the sequencer waits at its last step only if the earlier result is still there.
`default_nettype none

module iir_direct_form2_filter_unit #(
	parameter int ORDER       = 6,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 32
) (
	input wire           clk,
	input wire           arst_n,
	iirdf2_in_if.sink    sample_ch,
	iirdf2_out_if.source result_ch,
	iirdf2_cfg_if.sink   cfg_ch
);
	import iirdf2_pkg::*;

	localparam int ACC_BITS = W_BITS + 4 + $clog2(ORDER + 2) + 1;
	localparam int TAP_W    = $clog2(ORDER + 1);
	localparam int PIDX_W   = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int XSH      = W_FRAC + 1 - SAMPLE_BITS;
	localparam int YSH      = W_FRAC - OUT_FRAC;

	seq_state_t state_q;
	seq_state_t state_d;

	logic [TAP_W-1:0]  tap_q;
	logic              half_q;
	logic [PIDX_W-1:0] pidx;

	logic signed [COEF_BITS-1:0] coef_b_q [0:ORDER];
	logic signed [COEF_BITS-1:0] coef_a_q [1:ORDER];
	logic signed [W_BITS-1:0]    past_q [0:ORDER-1];
	logic signed [W_BITS-1:0]    w_q;
	logic                        wsat_q;

	logic                        res_valid_q;
	logic signed [OUT_BITS-1:0]  res_data_q;
	logic                        res_sat_q;

	logic                        cfg_wr;
	coef_slot_t                  sh;
	coef_slot_t                  sl;
	logic signed [COEF_BITS-1:0] coef_hi;
	logic signed [COEF_BITS-1:0] coef_lo;

	mac_ctl_t                    ctl;
	logic signed [COEF_BITS-1:0] mac_coef;
	logic signed [W_BITS-1:0]    mac_w;
	logic signed [ACC_BITS-1:0]  init_val;
	logic signed [ACC_BITS-1:0]  x_ext;
	logic signed [ACC_BITS-1:0]  acc;
	logic                        busy;

	logic                        accept;
	logic                        last_issue;
	logic                        done_out;
	logic                        w_ovf;
	logic signed [W_BITS-1:0]    w_clip;
	logic                        y_ovf;
	logic signed [OUT_BITS-1:0]  y_clip;

	// Configuration decode: each 32-bit half feeds at most one coefficient.
	assign cfg_ch.ready = 1'b1;
	assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;
	assign sh           = slot_hi(cfg_ch.index);
	assign sl           = slot_lo(cfg_ch.index);
	assign coef_hi      = cfg_ch.data[HALF_BITS +: COEF_BITS];
	assign coef_lo      = cfg_ch.data[0 +: COEF_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ORDER; i++) begin
				coef_b_q[i] <= '0;
			end
			for (int i = 1; i <= ORDER; i++) begin
				coef_a_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			for (int i = 0; i <= ORDER; i++) begin
				if (sh.en && !sh.is_a && int'(sh.idx) == i) begin
					coef_b_q[i] <= coef_hi;
				end
				if (sl.en && !sl.is_a && int'(sl.idx) == i) begin
					coef_b_q[i] <= coef_lo;
				end
			end
			for (int i = 1; i <= ORDER; i++) begin
				if (sh.en && sh.is_a && int'(sh.idx) == i) begin
					coef_a_q[i] <= coef_hi;
				end
				if (sl.en && sl.is_a && int'(sl.idx) == i) begin
					coef_a_q[i] <= coef_lo;
				end
			end
		end
	end

	// Handshake qualifiers and sequencer conditions.
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign accept          = sample_ch.valid & sample_ch.ready;
	assign last_issue      = half_q && (tap_q == TAP_W'(ORDER));
	assign done_out        = (state_q == ST_DONE) && (!res_valid_q || result_ch.ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) state_d = ST_FB;
			ST_FB:       if (last_issue) state_d = ST_FB_DRAIN;
			ST_FB_DRAIN: if (!busy) state_d = ST_WSAT;
			ST_WSAT:     state_d = ST_FF;
			ST_FF:       if (last_issue) state_d = ST_FF_DRAIN;
			ST_FF_DRAIN: if (!busy) state_d = ST_DONE;
			ST_DONE:     if (done_out) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				tap_q  <= TAP_W'(1);
				half_q <= 1'b0;
			end else if (state_q == ST_WSAT) begin
				tap_q  <= '0;
				half_q <= 1'b0;
			end else if (state_q == ST_FB || state_q == ST_FF) begin
				half_q <= ~half_q;
				if (half_q) begin
					tap_q <= tap_q + TAP_W'(1);
				end
			end
		end
	end

	// Sequencer outputs to the shared unit.
	assign pidx  = PIDX_W'(tap_q - TAP_W'(1));
	assign x_ext = $signed({{(ACC_BITS-SAMPLE_BITS){sample_ch.sample_in[SAMPLE_BITS-1]}},
	                        sample_ch.sample_in}) <<< XSH;

	always_comb begin
		ctl       = '0;
		ctl.issue = (state_q == ST_FB) || (state_q == ST_FF);
		ctl.hi    = half_q;
		ctl.sub   = (state_q == ST_FB);
		ctl.init  = accept || (state_q == ST_WSAT);
		init_val  = (state_q == ST_IDLE) ? x_ext : '0;
		if (state_q == ST_FB) begin
			mac_coef = coef_a_q[tap_q];
		end else begin
			mac_coef = coef_b_q[tap_q];
		end
		if (state_q == ST_FF && tap_q == '0) begin
			mac_w = w_q;
		end else begin
			mac_w = past_q[pidx];
		end
	end

	iirdf2_mac #(
		.COEF_BITS (COEF_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.coef     (mac_coef),
		.wval     (mac_w),
		.init_val (init_val),
		.acc      (acc),
		.busy     (busy)
	);

	// Clip the feedback sum to the delay-line format.
	assign w_ovf  = ~((&acc[ACC_BITS-1:W_BITS-1]) | ~(|acc[ACC_BITS-1:W_BITS-1]));
	assign w_clip = w_ovf ? (acc[ACC_BITS-1] ? $signed({1'b1, {(W_BITS-1){1'b0}}})
	                                         : $signed({1'b0, {(W_BITS-1){1'b1}}}))
	                      : acc[W_BITS-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_WSAT) begin
			w_q    <= w_clip;
			wsat_q <= w_ovf;
		end
	end

	// Round the output towards minus infinity to Q8.24 and clip it.
	assign y_ovf  = ~((&acc[ACC_BITS-1:OUT_BITS-1+YSH]) | ~(|acc[ACC_BITS-1:OUT_BITS-1+YSH]));
	assign y_clip = y_ovf ? (acc[ACC_BITS-1] ? $signed({1'b1, {(OUT_BITS-1){1'b0}}})
	                                         : $signed({1'b0, {(OUT_BITS-1){1'b1}}}))
	                      : acc[OUT_BITS-1+YSH:YSH];

	// Delay line shifts when the result is loaded into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				past_q[i] <= '0;
			end
		end else if (done_out) begin
			past_q[0] <= w_q;
			for (int i = 1; i < ORDER; i++) begin
				past_q[i] <= past_q[i-1];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_out) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_out) begin
			res_data_q <= y_clip;
			res_sat_q  <= y_ovf | wsat_q;
		end
	end

	assign result_ch.valid        = res_valid_q;
	assign result_ch.filtered_out = res_data_q;
	assign result_ch.saturated    = res_sat_q;

endmodule

`default_nettype wire
